/* hw/rtl/z80a_pkg.sv */
// Shared definitions for the Z80 8-bit arithmetic ALU: opcodes, flag bit
// positions, beat widths and the ALU result bundle.
// No dependencies.
package z80a_pkg;

   localparam int DATA_W = 8;
   localparam int OP_W = 3;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 24;

   // OP_NONE is the undefined opcode, which the ALU treats as a no-op.
   typedef enum logic [OP_W-1:0] {
      OP_ADD  = 3'd0,
      OP_ADC  = 3'd1,
      OP_SUB  = 3'd2,
      OP_SBC  = 3'd3,
      OP_CP   = 3'd4,
      OP_INC  = 3'd5,
      OP_DEC  = 3'd6,
      OP_NONE = 3'd7
   } op_type;

   // Flag byte bit positions.
   localparam int FLAG_C  = 0;
   localparam int FLAG_N  = 1;
   localparam int FLAG_PV = 2;
   localparam int FLAG_F3 = 3;
   localparam int FLAG_H  = 4;
   localparam int FLAG_F5 = 5;
   localparam int FLAG_Z  = 6;
   localparam int FLAG_S  = 7;

   localparam logic [3:0]        NIBBLE_MASK = 4'hF;
   localparam logic [DATA_W-1:0] INC_OVF_VALUE = 8'h7F;
   localparam logic [DATA_W-1:0] SIGN_BIT = 8'h80;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic [DATA_W-1:0] acc;
      logic [DATA_W-1:0] flags;
   } result_type;

endpackage

/* hw/rtl/z80a_alu.sv */
// Combinational arithmetic core: one opcode and operand against the current
// accumulator and flags gives the result value, new accumulator and flags.
// Depends on z80a_pkg.
module z80a_alu (
   input  logic [z80a_pkg::OP_W-1:0]   op,
   input  logic [z80a_pkg::DATA_W-1:0] operand,
   input  logic [z80a_pkg::DATA_W-1:0] acc,
   input  logic [z80a_pkg::DATA_W-1:0] flags,
   output z80a_pkg::result_type        result
);

   logic                          cin;
   logic                          use_carry;
   logic [z80a_pkg::DATA_W:0]     add_full;
   logic [4:0]                    add_half;
   logic [z80a_pkg::DATA_W:0]     sub_full;
   logic [4:0]                    sub_half;
   logic [z80a_pkg::DATA_W-1:0]   inc_res;
   logic [z80a_pkg::DATA_W-1:0]   dec_res;
   logic [z80a_pkg::DATA_W-1:0]   res;
   logic [z80a_pkg::DATA_W-1:0]   xy;
   logic [z80a_pkg::DATA_W-1:0]   f;

   assign use_carry = (op == z80a_pkg::OP_ADC) || (op == z80a_pkg::OP_SBC);
   assign cin = use_carry & flags[z80a_pkg::FLAG_C];

   // Bit 8 of the subtract is the borrow, bit 4 of the nibble subtract the half borrow.
   assign add_full = {1'b0, acc} + {1'b0, operand} + {8'd0, cin};
   assign add_half = {1'b0, acc[3:0]} + {1'b0, operand[3:0]} + {4'd0, cin};
   assign sub_full = {1'b0, acc} - {1'b0, operand} - {8'd0, cin};
   assign sub_half = {1'b0, acc[3:0]} - {1'b0, operand[3:0]} - {4'd0, cin};
   assign inc_res = operand + 8'd1;
   assign dec_res = operand - 8'd1;

   always_comb begin
      res = '0;
      xy = '0;
      f = flags;
      result.acc = acc;
      case (op)
         z80a_pkg::OP_ADD, z80a_pkg::OP_ADC: begin
            res = add_full[7:0];
            xy = res;
            f = '0;
            f[z80a_pkg::FLAG_C] = add_full[8];
            f[z80a_pkg::FLAG_H] = add_half[4];
            f[z80a_pkg::FLAG_PV] = ~(acc[7] ^ operand[7]) & (acc[7] ^ res[7]);
            result.acc = res;
         end
         z80a_pkg::OP_SUB, z80a_pkg::OP_SBC, z80a_pkg::OP_CP: begin
            res = sub_full[7:0];
            // Compare takes the undocumented bits from the operand.
            xy = (op == z80a_pkg::OP_CP) ? operand : res;
            f = '0;
            f[z80a_pkg::FLAG_N] = 1'b1;
            f[z80a_pkg::FLAG_C] = sub_full[8];
            f[z80a_pkg::FLAG_H] = sub_half[4];
            f[z80a_pkg::FLAG_PV] = (acc[7] ^ operand[7]) & (acc[7] ^ res[7]);
            if (op != z80a_pkg::OP_CP) begin
               result.acc = res;
            end
         end
         z80a_pkg::OP_INC: begin
            res = inc_res;
            xy = res;
            f = '0;
            f[z80a_pkg::FLAG_C] = flags[z80a_pkg::FLAG_C];
            f[z80a_pkg::FLAG_H] = (operand[3:0] == z80a_pkg::NIBBLE_MASK);
            f[z80a_pkg::FLAG_PV] = (operand == z80a_pkg::INC_OVF_VALUE);
         end
         z80a_pkg::OP_DEC: begin
            res = dec_res;
            xy = res;
            f = '0;
            f[z80a_pkg::FLAG_N] = 1'b1;
            f[z80a_pkg::FLAG_C] = flags[z80a_pkg::FLAG_C];
            f[z80a_pkg::FLAG_H] = (operand[3:0] == 4'd0);
            f[z80a_pkg::FLAG_PV] = (operand == z80a_pkg::SIGN_BIT);
         end
         default: begin
            // Undefined opcode leaves the state as it is and returns zero.
            res = '0;
            xy = '0;
            f = flags;
         end
      endcase
      if (op != z80a_pkg::OP_NONE) begin
         f[z80a_pkg::FLAG_S] = res[7];
         f[z80a_pkg::FLAG_Z] = (res == '0);
         f[z80a_pkg::FLAG_F5] = xy[5];
         f[z80a_pkg::FLAG_F3] = xy[3];
      end
      result.value = res;
      result.flags = f;
   end

endmodule

/* hw/rtl/z80_alu_8bit_arith_flags.sv */
// Z80 8-bit arithmetic ALU with accumulator and flag byte (ADD, ADC, SUB, SBC,
// CP, INC, DEC). One beat is taken every cycle unless a stalled result has filled
// both registers. A request beat lands in the input register, and the ALU stage
// then writes the result register, which offers the result beat. A stalled
// result holds the input register; a request is refused only while both registers
// are full. The accumulator and flags update in the ALU stage, so each operation
// sees the state left by the one just before it. Opcode 7 is a no-op that returns
// zero and the unchanged state. Depends on z80a_pkg and z80a_alu.
module z80_alu_8bit_arith_flags (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [2:0] op, [10:3] operand, [15:11] zero
   input  logic [z80a_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] result_value, [15:8] accumulator_out, [23:16] flags_out
   output logic [z80a_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   logic                            in_valid_ff;
   logic                            in_valid_in;
   logic [z80a_pkg::OP_W-1:0]       op_ff;
   logic [z80a_pkg::DATA_W-1:0]     operand_ff;
   logic                            out_valid_ff;
   logic                            out_valid_in;
   z80a_pkg::result_type            out_ff;
   logic [z80a_pkg::DATA_W-1:0]     acc_ff;
   logic [z80a_pkg::DATA_W-1:0]     flags_ff;
   z80a_pkg::result_type            alu_result;
   logic                            out_free;
   logic                            advance;
   logic                            req_beat;

   assign out_free = !out_valid_ff || rsp_tready;
   assign advance = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_beat = req_tvalid && req_tready;

   assign in_valid_in = req_beat || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   z80a_alu u_alu (
      .op      (op_ff),
      .operand (operand_ff),
      .acc     (acc_ff),
      .flags   (flags_ff),
      .result  (alu_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff <= '0;
         flags_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            acc_ff <= alu_result.acc;
            flags_ff <= alu_result.flags;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         op_ff <= req_tdata[z80a_pkg::OP_W-1:0];
         operand_ff <= req_tdata[z80a_pkg::OP_W +: z80a_pkg::DATA_W];
      end
      if (advance) begin
         out_ff <= alu_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {out_ff.flags, out_ff.acc, out_ff.value};

endmodule

/* hw/rtl/z80a_checker.sv */
// Port-level checks for the Z80 arithmetic ALU, bound to the top level.
// Depends on z80a_pkg and z80_alu_8bit_arith_flags.
module z80a_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [z80a_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   // A stalled result beat holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // Nothing is offered in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // A request beat is refused only while a result beat is stalled.
   a_req_refused: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request refused while the result side is free");

   // Only a real operation yields a nonzero value, and then S and Z follow it.
   a_sz_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[7:0] != 8'd0) |->
         !rsp_tdata[16 + z80a_pkg::FLAG_Z] &&
         (rsp_tdata[16 + z80a_pkg::FLAG_S] == rsp_tdata[7]))
      else $error("S or Z flag disagrees with result value");

endmodule

bind z80_alu_8bit_arith_flags z80a_checker u_z80a_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
